// File: hw/rtl/m3r_pkg.sv
// m3r_pkg: shared constants, codes, types and tables for the 3D mesh router node
// no dependencies; compiled first
package m3r_pkg;

    localparam int NPORTS       = 7;
    localparam int PORT_BITS    = 3;
    localparam int COORD_BITS   = 8;
    localparam int STAMP_BITS   = 32;
    localparam int PAYLOAD_BITS = 32;
    localparam int STATUS_BITS  = 3;
    localparam int CNT_BITS     = $clog2(NPORTS + 1);
    localparam int CFG_IDX_BITS = 2;
    localparam int CFG_DATA_BITS = (COORD_BITS > NPORTS) ? COORD_BITS : NPORTS;

    // port numbering
    localparam logic [PORT_BITS-1:0] P_LOCAL = 3'd0;
    localparam logic [PORT_BITS-1:0] P_NORTH = 3'd1;
    localparam logic [PORT_BITS-1:0] P_SOUTH = 3'd2;
    localparam logic [PORT_BITS-1:0] P_WEST  = 3'd3;
    localparam logic [PORT_BITS-1:0] P_EAST  = 3'd4;
    localparam logic [PORT_BITS-1:0] P_UP    = 3'd5;
    localparam logic [PORT_BITS-1:0] P_DOWN  = 3'd6;

    // result status codes
    localparam logic [STATUS_BITS-1:0] ST_IDLE    = 3'd0;
    localparam logic [STATUS_BITS-1:0] ST_SENT    = 3'd1;
    localparam logic [STATUS_BITS-1:0] ST_BLOCKED = 3'd2;
    localparam logic [STATUS_BITS-1:0] ST_UNCONN  = 3'd3;
    localparam logic [STATUS_BITS-1:0] ST_RX_OK   = 3'd4;
    localparam logic [STATUS_BITS-1:0] ST_RX_BUSY = 3'd5;

    // request kinds
    localparam logic REQ_RX   = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_NODE_X    = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NODE_Y    = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NODE_Z    = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_PORT_CONN = 2'd3;

    localparam logic [NPORTS-1:0] CONN_RESET = '1;

    // outputs are served in this order on a tick
    localparam logic [PORT_BITS-1:0] SERVE_ORDER [NPORTS] =
        '{P_EAST, P_WEST, P_NORTH, P_SOUTH, P_UP, P_DOWN, P_LOCAL};

    typedef logic [PORT_BITS-1:0] t_port;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic [COORD_BITS-1:0] z;
    } t_node;

    typedef struct packed {
        logic  found;
        t_port slot;
    } t_grant;

    // tie break rank: local, north, south, east, west, up, down
    function automatic logic [PORT_BITS-1:0] tie_rank(input t_port p);
        logic [PORT_BITS-1:0] r;
        case (p)
            P_LOCAL: r = 3'd0;
            P_NORTH: r = 3'd1;
            P_SOUTH: r = 3'd2;
            P_EAST:  r = 3'd3;
            P_WEST:  r = 3'd4;
            P_UP:    r = 3'd5;
            P_DOWN:  r = 3'd6;
            default: r = 3'd7;
        endcase
        return r;
    endfunction

endpackage

// File: hw/rtl/m3r_in_if.sv
// m3r_in_if: request channel into the router node (valid/ready plus fields)
// depends on m3r_pkg
interface m3r_in_if;
    import m3r_pkg::*;

    logic                    valid;
    logic                    ready;
    logic                    req_type;
    logic [PORT_BITS-1:0]    in_port;
    logic [COORD_BITS-1:0]   dest_x;
    logic [COORD_BITS-1:0]   dest_y;
    logic [COORD_BITS-1:0]   dest_z;
    logic [STAMP_BITS-1:0]   in_stamp;
    logic [PAYLOAD_BITS-1:0] in_payload;
    logic [NPORTS-1:0]       out_ready;

    modport source (
        output valid, req_type, in_port, dest_x, dest_y, dest_z, in_stamp, in_payload,
               out_ready,
        input  ready
    );
    modport sink (
        input  valid, req_type, in_port, dest_x, dest_y, dest_z, in_stamp, in_payload,
               out_ready,
        output ready
    );
endinterface

// File: hw/rtl/m3r_out_if.sv
// m3r_out_if: result channel out of the router node (valid/ready plus fields)
// depends on m3r_pkg
interface m3r_out_if;
    import m3r_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [STATUS_BITS-1:0]  status;
    logic [PORT_BITS-1:0]    out_port;
    logic [COORD_BITS-1:0]   out_dest_x;
    logic [COORD_BITS-1:0]   out_dest_y;
    logic [COORD_BITS-1:0]   out_dest_z;
    logic [STAMP_BITS-1:0]   out_stamp;
    logic [PAYLOAD_BITS-1:0] out_payload;
    logic                    last;

    modport source (
        output valid, status, out_port, out_dest_x, out_dest_y, out_dest_z, out_stamp,
               out_payload, last,
        input  ready
    );
    modport sink (
        input  valid, status, out_port, out_dest_x, out_dest_y, out_dest_z, out_stamp,
               out_payload, last,
        output ready
    );
endinterface

// File: hw/rtl/m3r_arb.sv
// m3r_arb: xyz route of every held packet and oldest-first pick per output port
// depends on m3r_pkg; purely combinational
module m3r_arb (
    input  m3r_pkg::t_node                                            i_node,
    input  logic [m3r_pkg::NPORTS-1:0]                                i_vld,
    input  logic [m3r_pkg::NPORTS-1:0][m3r_pkg::COORD_BITS-1:0]       i_dx,
    input  logic [m3r_pkg::NPORTS-1:0][m3r_pkg::COORD_BITS-1:0]       i_dy,
    input  logic [m3r_pkg::NPORTS-1:0][m3r_pkg::COORD_BITS-1:0]       i_dz,
    input  logic [m3r_pkg::NPORTS-1:0][m3r_pkg::STAMP_BITS-1:0]       i_stamp,
    output m3r_pkg::t_grant [m3r_pkg::NPORTS-1:0]                     o_grant
);
    import m3r_pkg::*;

    t_port                          w_route [NPORTS];
    logic [NPORTS-1:0][NPORTS-1:0]  w_beats;
    logic [NPORTS-1:0][NPORTS-1:0]  w_want;   // [output][slot]
    logic [NPORTS-1:0][NPORTS-1:0]  w_win;

    function automatic t_port route_of(
        input logic [COORD_BITS-1:0] x,
        input logic [COORD_BITS-1:0] y,
        input logic [COORD_BITS-1:0] z,
        input t_node                 n
    );
        t_port r;
        if (x > n.x)      r = P_EAST;
        else if (x < n.x) r = P_WEST;
        else if (y > n.y) r = P_NORTH;
        else if (y < n.y) r = P_SOUTH;
        else if (z > n.z) r = P_UP;
        else if (z < n.z) r = P_DOWN;
        else              r = P_LOCAL;
        return r;
    endfunction

    always_comb begin
        for (int i = 0; i < NPORTS; i++) begin
            w_route[i] = route_of(i_dx[i], i_dy[i], i_dz[i], i_node);
        end
        // pairwise age compare shared by all outputs
        for (int i = 0; i < NPORTS; i++) begin
            for (int j = 0; j < NPORTS; j++) begin
                w_beats[i][j] = (i_stamp[i] < i_stamp[j]) ||
                                ((i_stamp[i] == i_stamp[j]) &&
                                 (tie_rank(PORT_BITS'(i)) < tie_rank(PORT_BITS'(j))));
            end
        end
        for (int o = 0; o < NPORTS; o++) begin
            for (int i = 0; i < NPORTS; i++) begin
                w_want[o][i] = i_vld[i] && (w_route[i] == PORT_BITS'(o));
            end
        end
        for (int o = 0; o < NPORTS; o++) begin
            for (int i = 0; i < NPORTS; i++) begin
                w_win[o][i] = w_want[o][i];
                for (int j = 0; j < NPORTS; j++) begin
                    if (j != i && w_want[o][j] && !w_beats[i][j]) begin
                        w_win[o][i] = 1'b0;
                    end
                end
            end
        end
        for (int o = 0; o < NPORTS; o++) begin
            o_grant[o].found = |w_win[o];
            o_grant[o].slot  = '0;
            for (int i = 0; i < NPORTS; i++) begin
                if (w_win[o][i]) begin
                    o_grant[o].slot = PORT_BITS'(i);
                end
            end
        end
    end

endmodule

// File: hw/rtl/mesh3d_router_node_top.sv
// mesh3d_router_node_top: 3D mesh router node with one packet register per input port
// depends on m3r_pkg, m3r_in_if, m3r_out_if and m3r_arb
//
// A request is taken into an input register and handled in one pass once the result
// buffer is free: a receive stores the packet in its port register if that is free (local
// packets get the current tick count as stamp) and yields one result; a tick bumps the
// saturating tick count, routes every held packet x then y then z, picks the oldest per
// output and yields seven results, one per output in the order east, west, north, south,
// up, down, local. Results leave through a result buffer one per cycle while the result
// channel is ready; the next request is handled as the last result of the previous one
// is taken. Configuration writes are meant for idle periods only.
module mesh3d_router_node_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [m3r_pkg::CFG_IDX_BITS-1:0]    i_cfg_idx,
    input  logic [m3r_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    m3r_in_if.sink                              i_req,
    m3r_out_if.source                           o_res
);
    import m3r_pkg::*;

    localparam logic [CNT_BITS-1:0] CNT_ONE  = CNT_BITS'(1);
    localparam logic [CNT_BITS-1:0] CNT_TICK = CNT_BITS'(NPORTS);
    localparam t_port               LAST_POS = PORT_BITS'(NPORTS - 1);
    localparam logic [STAMP_BITS-1:0] STAMP_MAX = '1;

    // configuration
    t_node             r_node;
    logic [NPORTS-1:0] r_conn;

    // input register
    logic                    r_in_vld;
    logic                    r_in_type;
    t_port                   r_in_port;
    logic [COORD_BITS-1:0]   r_in_dx;
    logic [COORD_BITS-1:0]   r_in_dy;
    logic [COORD_BITS-1:0]   r_in_dz;
    logic [STAMP_BITS-1:0]   r_in_stamp;
    logic [PAYLOAD_BITS-1:0] r_in_payload;
    logic [NPORTS-1:0]       r_in_ordy;

    // packet registers
    logic [NPORTS-1:0]                         r_slot_vld;
    logic [NPORTS-1:0][COORD_BITS-1:0]         r_slot_dx;
    logic [NPORTS-1:0][COORD_BITS-1:0]         r_slot_dy;
    logic [NPORTS-1:0][COORD_BITS-1:0]         r_slot_dz;
    logic [NPORTS-1:0][STAMP_BITS-1:0]         r_slot_stamp;
    logic [NPORTS-1:0][PAYLOAD_BITS-1:0]       r_slot_payload;
    logic [STAMP_BITS-1:0]                     r_tick;

    // result buffer
    logic [CNT_BITS-1:0]     r_cnt;
    t_port                   r_pos;
    logic                    r_is_tick;
    logic [STATUS_BITS-1:0]  r_rx_st;
    t_port                   r_rx_port;
    logic [STATUS_BITS-1:0]  r_tk_st [NPORTS];
    t_port                   r_tk_sl [NPORTS];

    t_grant [NPORTS-1:0]     w_grant;
    logic [STATUS_BITS-1:0]  w_tk_st [NPORTS];
    t_port                   w_tk_sl [NPORTS];
    logic [NPORTS-1:0]       w_clr;
    logic [NPORTS:0]         w_busy_map;
    logic                    w_rx_busy;
    logic                    w_pop;
    logic                    w_free;
    logic                    w_proc;
    logic                    w_last;
    logic [STATUS_BITS-1:0]  w_cur_st;
    logic                    w_has_pkt;
    t_port                   w_sl;

    m3r_arb u_arb (
        .i_node  (r_node),
        .i_vld   (r_slot_vld),
        .i_dx    (r_slot_dx),
        .i_dy    (r_slot_dy),
        .i_dz    (r_slot_dz),
        .i_stamp (r_slot_stamp),
        .o_grant (w_grant)
    );

    // handshake
    assign w_last = !r_is_tick || (r_pos == LAST_POS);
    assign w_pop  = o_res.valid && o_res.ready;
    assign w_free = (r_cnt == '0) || ((r_cnt == CNT_ONE) && w_pop);
    assign w_proc = r_in_vld && w_free;
    assign i_req.ready = i_rst_n && (!r_in_vld || w_free);

    // arrival port seven never has a register, so it always reads busy
    assign w_busy_map = {1'b1, r_slot_vld};
    assign w_rx_busy  = w_busy_map[r_in_port];

    // per-output decision for a tick
    always_comb begin
        t_port o;
        o     = P_LOCAL;
        w_clr = '0;
        for (int k = 0; k < NPORTS; k++) begin
            o          = SERVE_ORDER[k];
            w_tk_sl[k] = w_grant[o].slot;
            if (!w_grant[o].found) begin
                w_tk_st[k] = ST_IDLE;
            end else if (!r_conn[o]) begin
                w_tk_st[k] = ST_UNCONN;
            end else if (!r_in_ordy[o]) begin
                w_tk_st[k] = ST_BLOCKED;
            end else begin
                w_tk_st[k]             = ST_SENT;
                w_clr[w_grant[o].slot] = 1'b1;
            end
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node     <= '0;
            r_conn     <= CONN_RESET;
            r_in_vld   <= 1'b0;
            r_slot_vld <= '0;
            r_tick     <= '0;
            r_cnt      <= '0;
            r_pos      <= '0;
            r_is_tick  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_NODE_X:    r_node.x <= i_cfg_data[COORD_BITS-1:0];
                    CFG_NODE_Y:    r_node.y <= i_cfg_data[COORD_BITS-1:0];
                    CFG_NODE_Z:    r_node.z <= i_cfg_data[COORD_BITS-1:0];
                    CFG_PORT_CONN: r_conn   <= i_cfg_data[NPORTS-1:0];
                    default: ;
                endcase
            end

            if (i_req.valid && i_req.ready) begin
                r_in_vld <= 1'b1;
            end else if (w_proc) begin
                r_in_vld <= 1'b0;
            end

            if (w_proc) begin
                if (r_in_type == REQ_TICK) begin
                    r_slot_vld <= r_slot_vld & ~w_clr;
                    if (r_tick != STAMP_MAX) begin
                        r_tick <= r_tick + 1'b1;
                    end
                    r_is_tick <= 1'b1;
                    r_cnt     <= CNT_TICK;
                    r_pos     <= '0;
                end else begin
                    if (!w_rx_busy) begin
                        r_slot_vld[r_in_port] <= 1'b1;
                    end
                    r_is_tick <= 1'b0;
                    r_cnt     <= CNT_ONE;
                end
            end else if (w_pop) begin
                r_cnt <= r_cnt - CNT_ONE;
                if (!w_last) begin
                    r_pos <= r_pos + 1'b1;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) begin
            r_in_type    <= i_req.req_type;
            r_in_port    <= i_req.in_port;
            r_in_dx      <= i_req.dest_x;
            r_in_dy      <= i_req.dest_y;
            r_in_dz      <= i_req.dest_z;
            r_in_stamp   <= i_req.in_stamp;
            r_in_payload <= i_req.in_payload;
            r_in_ordy    <= i_req.out_ready;
        end
        if (w_proc) begin
            if (r_in_type == REQ_TICK) begin
                for (int k = 0; k < NPORTS; k++) begin
                    r_tk_st[k] <= w_tk_st[k];
                    r_tk_sl[k] <= w_tk_sl[k];
                end
            end else begin
                r_rx_st   <= w_rx_busy ? ST_RX_BUSY : ST_RX_OK;
                r_rx_port <= r_in_port;
                if (!w_rx_busy) begin
                    r_slot_dx[r_in_port]      <= r_in_dx;
                    r_slot_dy[r_in_port]      <= r_in_dy;
                    r_slot_dz[r_in_port]      <= r_in_dz;
                    r_slot_stamp[r_in_port]   <= (r_in_port == P_LOCAL) ? r_tick : r_in_stamp;
                    r_slot_payload[r_in_port] <= r_in_payload;
                end
            end
        end
    end

    // result channel
    assign w_cur_st  = r_is_tick ? r_tk_st[r_pos] : r_rx_st;
    assign w_has_pkt = r_is_tick && (w_cur_st != ST_IDLE);
    assign w_sl      = r_tk_sl[r_pos];

    assign o_res.valid       = (r_cnt != '0);
    assign o_res.status      = w_cur_st;
    assign o_res.out_port    = r_is_tick ? SERVE_ORDER[r_pos] : r_rx_port;
    assign o_res.out_dest_x  = w_has_pkt ? r_slot_dx[w_sl] : '0;
    assign o_res.out_dest_y  = w_has_pkt ? r_slot_dy[w_sl] : '0;
    assign o_res.out_dest_z  = w_has_pkt ? r_slot_dz[w_sl] : '0;
    assign o_res.out_stamp   = w_has_pkt ? r_slot_stamp[w_sl] : '0;
    assign o_res.out_payload = w_has_pkt ? r_slot_payload[w_sl] : '0;
    assign o_res.last        = w_last;

    // checks
    a_last_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.last) |-> (r_cnt == CNT_ONE))
        else $error("last result shown while more results remain");

    a_waiting_request_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !w_proc) |=> r_in_vld)
        else $error("waiting request dropped");

    a_tick_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rst_n |=> (r_tick >= $past(r_tick)))
        else $error("tick count went backward");

    a_sent_slot_freed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_proc && (r_in_type == REQ_TICK)) |=> ((r_slot_vld & $past(w_clr)) == '0))
        else $error("sent packet still held");

endmodule

// File: verif/mesh3d_router_node_top_tb.sv
// self-checking testbench for mesh3d_router_node_top: directed table then random requests,
// every result checked against an in-bench router predictor with random stalls on both sides
// depends on m3r_pkg, m3r_in_if, m3r_out_if and the router rtl
module mesh3d_router_node_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import m3r_pkg::*;

    localparam int    HOLD_CYCLES = 120;
    localparam int    QUIET_LIMIT = 3000;
    localparam t_port BAD_PORT    = 3'd7;

    typedef struct packed {
        logic                    is_tick;
        t_port                   port;
        t_node                   dest;
        logic [STAMP_BITS-1:0]   stamp;
        logic [PAYLOAD_BITS-1:0] payload;
        logic [NPORTS-1:0]       rdy;
    } t_req;

    typedef struct packed {
        logic [STATUS_BITS-1:0]  status;
        t_port                   port;
        t_node                   dest;
        logic [STAMP_BITS-1:0]   stamp;
        logic [PAYLOAD_BITS-1:0] payload;
        logic                    last;
    } t_hop;

    // status fixed by hand for a table row, applied to every result of that request
    typedef struct packed {
        logic                   on;
        logic [STATUS_BITS-1:0] status;
    } t_pinned;

    typedef struct packed {
        logic                     is_cfg;
        logic [CFG_IDX_BITS-1:0]  idx;
        logic [CFG_DATA_BITS-1:0] val;
        t_req                     rq;
        t_pinned                  pin;
    } t_step;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n;
    logic                     i_cfg_we;
    logic [CFG_IDX_BITS-1:0]  i_cfg_idx;
    logic [CFG_DATA_BITS-1:0] i_cfg_data;

    m3r_in_if  req_if ();
    m3r_out_if res_if ();

    mesh3d_router_node_top u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_if),
        .o_res      (res_if)
    );

    always #10 i_clk = ~i_clk;

    // predicted router state
    logic                    held_valid   [NPORTS];
    t_node                   held_dest    [NPORTS];
    logic [STAMP_BITS-1:0]   held_stamp   [NPORTS];
    logic [PAYLOAD_BITS-1:0] held_payload [NPORTS];
    logic [STAMP_BITS-1:0]   tick_cnt;
    t_node                   here;
    logic [NPORTS-1:0]       link_up;

    t_port srv_order [NPORTS] = '{P_EAST, P_WEST, P_NORTH, P_SOUTH, P_UP, P_DOWN, P_LOCAL};
    t_port tie_order [NPORTS] = '{P_LOCAL, P_NORTH, P_SOUTH, P_EAST, P_WEST, P_UP, P_DOWN};

    t_hop    hop_q [$];
    t_pinned pin_q [$];
    t_node   aim_node;
    int      errors       = 0;
    int      quiet_cycles = 0;
    bit      hold_rx      = 1'b0;

    function automatic t_port hop_dir(input t_node d);
        if (d.x > here.x) return P_EAST;
        if (d.x < here.x) return P_WEST;
        if (d.y > here.y) return P_NORTH;
        if (d.y < here.y) return P_SOUTH;
        if (d.z > here.z) return P_UP;
        if (d.z < here.z) return P_DOWN;
        return P_LOCAL;
    endfunction

    task automatic route_request(input t_req r, output int n, output t_hop res [NPORTS]);
        int    best;
        t_port o;
        t_port s;
        foreach (res[k]) res[k] = '0;
        if (!r.is_tick) begin
            n = 1;
            res[0].port = r.port;
            res[0].last = 1'b1;
            if (r.port >= NPORTS || held_valid[r.port]) begin
                res[0].status = ST_RX_BUSY;
            end else begin
                held_valid[r.port]   = 1'b1;
                held_dest[r.port]    = r.dest;
                held_stamp[r.port]   = (r.port == P_LOCAL) ? tick_cnt : r.stamp;
                held_payload[r.port] = r.payload;
                res[0].status = ST_RX_OK;
            end
        end else begin
            n = NPORTS;
            if (tick_cnt != '1) tick_cnt = tick_cnt + 1'b1;
            for (int k = 0; k < NPORTS; k++) begin
                o    = srv_order[k];
                best = -1;
                for (int t = 0; t < NPORTS; t++) begin
                    s = tie_order[t];
                    if (held_valid[s] && hop_dir(held_dest[s]) == o) begin
                        if (best < 0 || held_stamp[s] < held_stamp[best]) best = int'(s);
                    end
                end
                res[k].port = o;
                res[k].last = (k == NPORTS - 1);
                if (best < 0) begin
                    res[k].status = ST_IDLE;
                end else begin
                    res[k].dest    = held_dest[best];
                    res[k].stamp   = held_stamp[best];
                    res[k].payload = held_payload[best];
                    if (!link_up[o]) begin
                        res[k].status = ST_UNCONN;
                    end else if (!r.rdy[o]) begin
                        res[k].status = ST_BLOCKED;
                    end else begin
                        res[k].status = ST_SENT;
                        held_valid[best] = 1'b0;
                    end
                end
            end
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        end
    endtask

    // sample both channels at the edge: results belong to earlier requests, so compare first
    always @(posedge i_clk) begin : scoreboard
        t_hop    got;
        t_hop    want;
        t_hop    res [NPORTS];
        t_req    rq;
        t_pinned pin;
        int      n;
        bit      moved;
        if (i_rst_n === 1'b1) begin
            moved = 1'b0;
            if (res_if.valid === 1'b1 && res_if.ready === 1'b1) begin
                moved       = 1'b1;
                got.status  = res_if.status;
                got.port    = res_if.out_port;
                got.dest.x  = res_if.out_dest_x;
                got.dest.y  = res_if.out_dest_y;
                got.dest.z  = res_if.out_dest_z;
                got.stamp   = res_if.out_stamp;
                got.payload = res_if.out_payload;
                got.last    = res_if.last;
                if (hop_q.size() == 0) begin
                    errors++;
                    $display("%0t ns: unexpected result, expected none, actual %0h",
                             $time, got);
                end else begin
                    want = hop_q.pop_front();
                    check_field("status", 64'(want.status), 64'(got.status));
                    check_field("out_port", 64'(want.port), 64'(got.port));
                    check_field("out_dest_x", 64'(want.dest.x), 64'(got.dest.x));
                    check_field("out_dest_y", 64'(want.dest.y), 64'(got.dest.y));
                    check_field("out_dest_z", 64'(want.dest.z), 64'(got.dest.z));
                    check_field("out_stamp", 64'(want.stamp), 64'(got.stamp));
                    check_field("out_payload", 64'(want.payload), 64'(got.payload));
                    check_field("last", 64'(want.last), 64'(got.last));
                end
            end
            if (req_if.valid === 1'b1 && req_if.ready === 1'b1) begin
                moved      = 1'b1;
                rq.is_tick = req_if.req_type;
                rq.port    = req_if.in_port;
                rq.dest.x  = req_if.dest_x;
                rq.dest.y  = req_if.dest_y;
                rq.dest.z  = req_if.dest_z;
                rq.stamp   = req_if.in_stamp;
                rq.payload = req_if.in_payload;
                rq.rdy     = req_if.out_ready;
                pin        = pin_q.pop_front();
                route_request(rq, n, res);
                for (int k = 0; k < n; k++) begin
                    if (pin.on) res[k].status = pin.status;
                    hop_q.push_back(res[k]);
                end
            end
            if (i_cfg_we === 1'b1) begin
                case (i_cfg_idx)
                    CFG_NODE_X:    here.x  = i_cfg_data[COORD_BITS-1:0];
                    CFG_NODE_Y:    here.y  = i_cfg_data[COORD_BITS-1:0];
                    CFG_NODE_Z:    here.z  = i_cfg_data[COORD_BITS-1:0];
                    CFG_PORT_CONN: link_up = i_cfg_data[NPORTS-1:0];
                    default: ;
                endcase
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
        end
    end

    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("Some tests failed");
        $finish;
    end

    function automatic int sender_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    function automatic int stall_len();
        if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side: random stalls, plus one long hold-off on request
    initial begin : result_sink
        res_if.ready <= 1'b0;
        repeat (4) @(posedge i_clk);
        forever begin
            if (hold_rx) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_rx = 1'b0;
            end else begin
                res_if.ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(20, 60)) @(posedge i_clk);
                else
                    repeat ($urandom_range(1, 6)) @(posedge i_clk);
                if ($urandom_range(0, 1) == 0) begin
                    res_if.ready <= 1'b0;
                    repeat (stall_len()) @(posedge i_clk);
                end
            end
        end
    end

    function automatic logic [COORD_BITS-1:0] near(input logic [COORD_BITS-1:0] c);
        logic [COORD_BITS-1:0] v;
        case ($urandom_range(0, 5))
            0, 1:    v = c;
            2:       v = c + 1'b1;
            3:       v = c - 1'b1;
            4:       v = ($urandom_range(0, 1) == 0) ? '0 : '1;
            default: v = COORD_BITS'($urandom());
        endcase
        return v;
    endfunction

    function automatic t_req rand_req();
        t_req r;
        r.is_tick = ($urandom_range(0, 99) < 35);
        r.port    = ($urandom_range(0, 15) == 0) ? BAD_PORT : t_port'($urandom_range(0, 6));
        r.dest.x  = near(aim_node.x);
        r.dest.y  = near(aim_node.y);
        r.dest.z  = near(aim_node.z);
        case ($urandom_range(0, 3))
            0:       r.stamp = STAMP_BITS'($urandom_range(0, 3));
            1:       r.stamp = '1;
            default: r.stamp = STAMP_BITS'($urandom());
        endcase
        r.payload = PAYLOAD_BITS'($urandom());
        case ($urandom_range(0, 9))
            0:          r.rdy = '0;
            1, 2, 3, 4: r.rdy = NPORTS'($urandom());
            default:    r.rdy = '1;
        endcase
        return r;
    endfunction

    function automatic t_step rx_row(input t_port p, input logic [COORD_BITS-1:0] x,
                                     input logic [COORD_BITS-1:0] y,
                                     input logic [COORD_BITS-1:0] z,
                                     input logic [STAMP_BITS-1:0] st,
                                     input logic [PAYLOAD_BITS-1:0] pl,
                                     input logic [STATUS_BITS-1:0] want);
        t_step s;
        s            = '0;
        s.rq.port    = p;
        s.rq.dest    = '{x, y, z};
        s.rq.stamp   = st;
        s.rq.payload = pl;
        s.pin        = '{1'b1, want};
        return s;
    endfunction

    function automatic t_step tick_row(input logic [NPORTS-1:0] rdy, input bit pinned);
        t_step s;
        s            = '0;
        s.rq.is_tick = 1'b1;
        s.rq.rdy     = rdy;
        s.pin        = '{pinned, ST_IDLE};
        return s;
    endfunction

    function automatic t_step cfg_row(input logic [CFG_IDX_BITS-1:0] idx,
                                      input logic [CFG_DATA_BITS-1:0] val);
        t_step s;
        s        = '0;
        s.is_cfg = 1'b1;
        s.idx    = idx;
        s.val    = val;
        return s;
    endfunction

    task automatic offer(input t_req r, input t_pinned pin);
        pin_q.push_back(pin);
        req_if.valid      <= 1'b1;
        req_if.req_type   <= r.is_tick;
        req_if.in_port    <= r.port;
        req_if.dest_x     <= r.dest.x;
        req_if.dest_y     <= r.dest.y;
        req_if.dest_z     <= r.dest.z;
        req_if.in_stamp   <= r.stamp;
        req_if.in_payload <= r.payload;
        req_if.out_ready  <= r.rdy;
        @(posedge i_clk);
        while (req_if.ready !== 1'b1) @(posedge i_clk);
    endtask

    task automatic pause(input int n);
        if (n > 0) begin
            req_if.valid <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    // sender stops until every predicted result has been taken
    task automatic drain();
        req_if.valid <= 1'b0;
        do @(posedge i_clk); while (hop_q.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_NODE_X: aim_node.x = val[COORD_BITS-1:0];
            CFG_NODE_Y: aim_node.y = val[COORD_BITS-1:0];
            CFG_NODE_Z: aim_node.z = val[COORD_BITS-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        t_step                    dir_tbl [$];
        logic [CFG_DATA_BITS-1:0] cfg_val [4];
        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_idx         <= '0;
        i_cfg_data        <= '0;
        req_if.valid      <= 1'b0;
        req_if.req_type   <= REQ_RX;
        req_if.in_port    <= '0;
        req_if.dest_x     <= '0;
        req_if.dest_y     <= '0;
        req_if.dest_z     <= '0;
        req_if.in_stamp   <= '0;
        req_if.in_payload <= '0;
        req_if.out_ready  <= '0;
        foreach (held_valid[p]) held_valid[p] = 1'b0;
        tick_cnt = '0;
        here     = '0;
        aim_node = '0;
        link_up  = CONN_RESET;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty router after reset, bad arrival port, local stamping, full local register
        dir_tbl.push_back(tick_row('0, 1'b1));
        dir_tbl.push_back(rx_row(BAD_PORT, 8'd1, 8'd2, 8'd3, '1, '1, ST_RX_BUSY));
        dir_tbl.push_back(rx_row(P_LOCAL, '0, '0, '0, 32'h1234_5678, '0, ST_RX_OK));
        dir_tbl.push_back(rx_row(P_LOCAL, '1, '1, '1, '0, '1, ST_RX_BUSY));
        dir_tbl.push_back(tick_row('1, 1'b0));
        // node in the middle, east and up links down
        dir_tbl.push_back(cfg_row(CFG_NODE_X, 8'd128));
        dir_tbl.push_back(cfg_row(CFG_NODE_Y, 8'd128));
        dir_tbl.push_back(cfg_row(CFG_NODE_Z, 8'd128));
        dir_tbl.push_back(cfg_row(CFG_PORT_CONN, 8'h4F));
        // one packet per direction; north and south tie on all-ones stamps
        dir_tbl.push_back(rx_row(P_NORTH, '1, '0, '0, '1, '1, ST_RX_OK));
        dir_tbl.push_back(rx_row(P_SOUTH, 8'd200, 8'd9, 8'd9, '1, 32'hA5A5_5A5A, ST_RX_OK));
        dir_tbl.push_back(rx_row(P_WEST, '0, 8'd128, 8'd128, '0, '0, ST_RX_OK));
        dir_tbl.push_back(rx_row(P_EAST, 8'd128, '1, 8'd128, 32'd7, 32'h0F0F_F0F0, ST_RX_OK));
        dir_tbl.push_back(rx_row(P_UP, 8'd128, '0, 8'd128, 32'd3, 32'hFFFF_0000, ST_RX_OK));
        dir_tbl.push_back(rx_row(P_DOWN, 8'd128, 8'd128, '1, 32'd1, 32'h0000_FFFF, ST_RX_OK));
        dir_tbl.push_back(rx_row(P_LOCAL, 8'd128, 8'd128, '0, '1, 32'h8000_0001, ST_RX_OK));
        dir_tbl.push_back(tick_row('0, 1'b0));
        dir_tbl.push_back(tick_row('1, 1'b0));
        dir_tbl.push_back(cfg_row(CFG_PORT_CONN, 8'h7F));
        dir_tbl.push_back(tick_row('1, 1'b0));
        dir_tbl.push_back(tick_row('1, 1'b0));
        // packet for this node: local output blocked, then sent
        dir_tbl.push_back(rx_row(P_LOCAL, 8'd128, 8'd128, 8'd128, '0, 32'hDEAD_BEEF, ST_RX_OK));
        dir_tbl.push_back(tick_row(7'h7E, 1'b0));
        dir_tbl.push_back(tick_row(7'h01, 1'b0));

        foreach (dir_tbl[i]) begin
            if (dir_tbl[i].is_cfg) begin
                drain();
                write_reg(dir_tbl[i].idx, dir_tbl[i].val);
            end else begin
                offer(dir_tbl[i].rq, dir_tbl[i].pin);
                pause(sender_gap());
            end
        end

        for (int ph = 0; ph < 6; ph++) begin
            case (ph)
                0:       cfg_val = '{8'd0, 8'd0, 8'd0, 8'h7F};
                1:       cfg_val = '{8'hFF, 8'hFF, 8'hFF, 8'h7F};
                2:       cfg_val = '{8'd128, 8'd64, 8'd200, 8'h00};
                3:       cfg_val = '{8'($urandom()), 8'($urandom()), 8'($urandom()),
                                     8'($urandom_range(0, 127))};
                4:       cfg_val = '{8'd1, 8'd254, 8'd17, 8'h7F};
                default: cfg_val = '{8'($urandom()), 8'($urandom()), 8'($urandom()), 8'h7F};
            endcase
            drain();
            write_reg(CFG_NODE_X, cfg_val[0]);
            write_reg(CFG_NODE_Y, cfg_val[1]);
            write_reg(CFG_NODE_Z, cfg_val[2]);
            write_reg(CFG_PORT_CONN, cfg_val[3]);
            if (ph == 1) begin
                // back-to-back requests against a stalled result side
                hold_rx = 1'b1;
                repeat (25) offer(rand_req(), '0);
            end
            repeat (44) begin
                offer(rand_req(), '0);
                if ($urandom_range(0, 19) == 0)
                    drain();
                else
                    pause(sender_gap());
            end
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (errors == 0 && hop_q.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
